FILE: sv/chained_hash_table_with_growth_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chained hash table
// Shared same-cycle and next-cycle implication property forms.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_WITH_GROWTH_MACROS_SVH
`define CHAINED_HASH_TABLE_WITH_GROWTH_MACROS_SVH

// same-cycle implication
`define CHTG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/chtg_pkg.sv
// ---------------------------------------------------------------------------
// chtg_pkg
// Field widths, codes and types of the chained hash table.
// ---------------------------------------------------------------------------
package chtg_pkg;

  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int OBKT_W     = 7;
  localparam int OITEM_W    = 10;
  localparam int DBL_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int THR_W      = 4;

  localparam logic [DBL_W-1:0]      DBL_MAX          = 3'd7;
  localparam logic [CFG_DATA_W-1:0] INIT_BUCKETS_RST = 7'd8;
  localparam logic [THR_W-1:0]      LOAD_THR_RST     = 4'd1;

  localparam logic                 FUNC_INSERT = 1'b0;
  localparam logic                 FUNC_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_BUCKETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_THR     = 2'd1;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CAPPED    = 3'd5
  } status_t;

endpackage

FILE: sv/chained_hash_table_with_growth.sv
// ---------------------------------------------------------------------------
// chained_hash_table_with_growth
// Key/value table in buckets of key mod m, doubling m under load.
// ---------------------------------------------------------------------------
// One request at a time. The bucket index comes from a bit-serial modulo
// unit, shared by hashing and rehashing. A doubling walks every old bucket,
// rehashing each stored entry, then rehashes and appends the new key.
// The next request is taken as soon as the result sits in the output
// register.
`include "chained_hash_table_with_growth_macros.svh"

module chained_hash_table_with_growth #(
  parameter int MAX_BUCKETS      = 64,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key[30:0], value[62:31]
  input  logic [0:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status, found_value, bucket_count,
                                  // item_count, resize_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [chtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chtg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int BKT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int BI_W   = $clog2(MAX_BUCKETS);
  localparam int SJ_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int NSLOT  = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int SA_W   = $clog2(NSLOT);
  localparam int ENT_W  = $clog2(NSLOT + 1);
  localparam int KEY_W  = chtg_pkg::KEY_W;
  localparam int VAL_W  = chtg_pkg::VAL_W;
  localparam int CNT_W  = $clog2(KEY_W + 1);
  localparam int LIM_W  = BKT_W + chtg_pkg::THR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_FWAIT, S_FCHK, S_SRD, S_SCMP, S_MISS, S_APPEND,
    S_DFWAIT, S_DFCHK, S_DSRD, S_DSQ, S_DMOD, S_DFW1, S_DFW2, S_DONE
  } state_t;

  function automatic logic [BKT_W-1:0] clamp_bkt(input logic [chtg_pkg::CFG_DATA_W-1:0] v);
    logic [BKT_W-1:0] r;
    if (v == '0) begin
      r = BKT_W'(1);
    end else if (32'(v) > MAX_BUCKETS) begin
      r = BKT_W'(MAX_BUCKETS);
    end else begin
      r = BKT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [SA_W-1:0] slot_addr(input logic [BI_W-1:0] b,
                                                input logic [SJ_W-1:0] j);
    return SA_W'(SA_W'(b) * SA_W'(SLOTS_PER_BUCKET)) + SA_W'(j);
  endfunction

  state_t state_r;

  logic                   func_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       val_r;
  logic                   grown_r;
  logic [BI_W-1:0]        b_r;
  logic [BI_W-1:0]        i_r;
  logic [SJ_W-1:0]        j_r;
  logic [FILL_W-1:0]      f_r;
  logic [FILL_W-1:0]      keep_r;
  logic [FILL_W-1:0]      moved_r;
  logic [KEY_W-1:0]       dk_r;
  logic [VAL_W-1:0]       dv_r;
  chtg_pkg::status_t      st_r;
  logic [VAL_W-1:0]       fval_r;

  logic [BKT_W-1:0]       bkt_r;
  logic [ENT_W-1:0]       ent_r;
  logic [chtg_pkg::DBL_W-1:0] dbl_r;
  logic [chtg_pkg::THR_W-1:0] thr_r;
  logic [MAX_BUCKETS-1:0] fv_r;
  logic                   fv_rd_r;

  logic                   mod_busy_r;
  logic [CNT_W-1:0]       mod_cnt_r;
  logic [KEY_W-1:0]       mod_sh_r;
  logic [BKT_W-1:0]       mod_div_r;
  logic [BKT_W-1:0]       mod_rem_r;
  logic [BKT_W:0]         mod_t;
  logic [BKT_W-1:0]       mod_rem_nxt;

  logic                   out_tvalid_r;
  chtg_pkg::status_t      o_status_r;
  logic [VAL_W-1:0]       o_fval_r;
  logic [chtg_pkg::OBKT_W-1:0]  o_bkt_r;
  logic [chtg_pkg::OITEM_W-1:0] o_items_r;
  logic [chtg_pkg::DBL_W-1:0]   o_rsz_r;

  logic                   slot_we;
  logic [SA_W-1:0]        slot_waddr;
  logic [KEY_W+VAL_W-1:0] slot_wdata;
  logic [SA_W-1:0]        slot_raddr;
  logic [KEY_W+VAL_W-1:0] slot_q;
  logic                   fill_we;
  logic [BI_W-1:0]        fill_waddr;
  logic [FILL_W-1:0]      fill_wdata;
  logic [BI_W-1:0]        fill_raddr;
  logic [FILL_W-1:0]      fill_ram_q;
  logic [FILL_W-1:0]      fill_q;

  logic [chtg_pkg::THR_W-1:0] thr_eff;
  logic [LIM_W-1:0]       lim;
  logic                   need_grow;
  logic                   grow_capped;
  logic [BKT_W-1:0]       bkt_dbl;
  logic [BI_W-1:0]        hi_b;
  logic                   j_more;
  logic                   in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, o_rsz_r, o_items_r, o_bkt_r, o_fval_r, o_status_r};

  assign mod_t       = {mod_rem_r, mod_sh_r[KEY_W-1]};
  assign mod_rem_nxt = (mod_t >= (BKT_W+1)'(mod_div_r)) ?
                       BKT_W'(mod_t - (BKT_W+1)'(mod_div_r)) : BKT_W'(mod_t);

  assign fill_q      = fv_rd_r ? fill_ram_q : '0;
  assign thr_eff     = (thr_r == '0) ? chtg_pkg::THR_W'(1) : thr_r;
  assign lim         = LIM_W'(thr_eff) * LIM_W'(bkt_r);
  assign need_grow   = (32'(ent_r) >= 32'(lim));
  assign grow_capped = ((32'(bkt_r) * 2) > MAX_BUCKETS);
  assign bkt_dbl     = BKT_W'({bkt_r, 1'b0});
  assign hi_b        = BI_W'(BKT_W'(i_r) + bkt_r);
  assign j_more      = ((FILL_W+1)'(j_r) + (FILL_W+1)'(1)) < (FILL_W+1)'(f_r);

  assign fill_raddr  = (state_r == S_DFWAIT) ? i_r : b_r;
  assign slot_raddr  = (state_r == S_DSRD) ? slot_addr(i_r, j_r) : slot_addr(b_r, j_r);

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_addr(b_r, j_r);
    slot_wdata = {val_r, key_r};
    fill_we    = 1'b0;
    fill_waddr = b_r;
    fill_wdata = FILL_W'(f_r + FILL_W'(1));
    unique case (state_r)
      S_SCMP: begin
        slot_we = (slot_q[KEY_W-1:0] == key_r) && (func_r == chtg_pkg::FUNC_INSERT);
      end
      S_APPEND: begin
        slot_waddr = slot_addr(b_r, SJ_W'(f_r));
        slot_we    = (32'(f_r) < SLOTS_PER_BUCKET);
        fill_we    = slot_we;
      end
      S_DMOD: begin
        slot_we    = !mod_busy_r;
        slot_wdata = {dv_r, dk_r};
        slot_waddr = (mod_rem_r == BKT_W'(i_r)) ? slot_addr(i_r, SJ_W'(keep_r)) :
                                                 slot_addr(hi_b, SJ_W'(moved_r));
      end
      S_DFW1: begin
        fill_we    = 1'b1;
        fill_waddr = i_r;
        fill_wdata = keep_r;
      end
      S_DFW2: begin
        fill_we    = 1'b1;
        fill_waddr = hi_b;
        fill_wdata = moved_r;
      end
      default: begin
      end
    endcase
  end

  chtg_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(NSLOT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_q)
  );

  chtg_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BUCKETS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_ram_q)
  );

  always_ff @(posedge clk) begin
    fv_rd_r <= fv_r[fill_raddr];
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mod_busy_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      fv_r         <= '0;
      bkt_r        <= clamp_bkt(chtg_pkg::INIT_BUCKETS_RST);
      ent_r        <= '0;
      dbl_r        <= '0;
      thr_r        <= chtg_pkg::LOAD_THR_RST;
      grown_r      <= 1'b0;
    end else begin
      if (mod_busy_r) begin
        mod_rem_r <= mod_rem_nxt;
        mod_sh_r  <= {mod_sh_r[KEY_W-2:0], 1'b0};
        mod_cnt_r <= mod_cnt_r - CNT_W'(1);
        if (mod_cnt_r == CNT_W'(1)) begin
          mod_busy_r <= 1'b0;
        end
      end
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      if (fill_we) begin
        fv_r[fill_waddr] <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r     <= in_tuser[0];
            key_r      <= in_tdata[KEY_W-1:0];
            val_r      <= in_tdata[KEY_W+VAL_W-1:KEY_W];
            fval_r     <= '0;
            grown_r    <= 1'b0;
            mod_busy_r <= 1'b1;
            mod_cnt_r  <= CNT_W'(KEY_W);
            mod_sh_r   <= in_tdata[KEY_W-1:0];
            mod_div_r  <= bkt_r;
            mod_rem_r  <= '0;
            state_r    <= S_HASH;
          end
        end
        S_HASH: begin
          if (!mod_busy_r) begin
            b_r     <= BI_W'(mod_rem_r);
            state_r <= S_FWAIT;
          end
        end
        S_FWAIT: state_r <= S_FCHK;
        S_FCHK: begin
          f_r <= fill_q;
          j_r <= '0;
          if (grown_r) begin
            state_r <= S_APPEND;
          end else if (fill_q == '0) begin
            state_r <= S_MISS;
          end else begin
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SCMP;
        S_SCMP: begin
          if (slot_q[KEY_W-1:0] == key_r) begin
            if (func_r == chtg_pkg::FUNC_LOOKUP) begin
              st_r   <= chtg_pkg::ST_FOUND;
              fval_r <= slot_q[KEY_W+VAL_W-1:KEY_W];
            end else begin
              st_r <= chtg_pkg::ST_UPDATED;
            end
            state_r <= S_DONE;
          end else if (j_more) begin
            j_r     <= j_r + SJ_W'(1);
            state_r <= S_SRD;
          end else begin
            state_r <= S_MISS;
          end
        end
        S_MISS: begin
          if (func_r == chtg_pkg::FUNC_LOOKUP) begin
            st_r    <= chtg_pkg::ST_NOT_FOUND;
            state_r <= S_DONE;
          end else if (need_grow && grow_capped) begin
            st_r    <= chtg_pkg::ST_CAPPED;
            state_r <= S_DONE;
          end else if (need_grow) begin
            i_r     <= '0;
            state_r <= S_DFWAIT;
          end else begin
            state_r <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (32'(f_r) >= SLOTS_PER_BUCKET) begin
            st_r <= chtg_pkg::ST_FULL;
          end else begin
            st_r  <= chtg_pkg::ST_INSERTED;
            ent_r <= ent_r + ENT_W'(1);
          end
          state_r <= S_DONE;
        end
        S_DFWAIT: state_r <= S_DFCHK;
        S_DFCHK: begin
          f_r     <= fill_q;
          j_r     <= '0;
          keep_r  <= '0;
          moved_r <= '0;
          state_r <= (fill_q == '0) ? S_DFW1 : S_DSRD;
        end
        S_DSRD: state_r <= S_DSQ;
        S_DSQ: begin
          dk_r       <= slot_q[KEY_W-1:0];
          dv_r       <= slot_q[KEY_W+VAL_W-1:KEY_W];
          mod_busy_r <= 1'b1;
          mod_cnt_r  <= CNT_W'(KEY_W);
          mod_sh_r   <= slot_q[KEY_W-1:0];
          mod_div_r  <= bkt_dbl;
          mod_rem_r  <= '0;
          state_r    <= S_DMOD;
        end
        S_DMOD: begin
          if (!mod_busy_r) begin
            if (mod_rem_r == BKT_W'(i_r)) begin
              keep_r <= keep_r + FILL_W'(1);
            end else begin
              moved_r <= moved_r + FILL_W'(1);
            end
            j_r     <= j_r + SJ_W'(1);
            state_r <= j_more ? S_DSRD : S_DFW1;
          end
        end
        S_DFW1: state_r <= S_DFW2;
        S_DFW2: begin
          if ((BKT_W'(i_r) + BKT_W'(1)) == bkt_r) begin
            bkt_r      <= bkt_dbl;
            if (dbl_r != chtg_pkg::DBL_MAX) begin
              dbl_r <= dbl_r + chtg_pkg::DBL_W'(1);
            end
            grown_r    <= 1'b1;
            mod_busy_r <= 1'b1;
            mod_cnt_r  <= CNT_W'(KEY_W);
            mod_sh_r   <= key_r;
            mod_div_r  <= bkt_dbl;
            mod_rem_r  <= '0;
            state_r    <= S_HASH;
          end else begin
            i_r     <= i_r + BI_W'(1);
            state_r <= S_DFWAIT;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            o_status_r   <= st_r;
            o_fval_r     <= fval_r;
            o_bkt_r      <= chtg_pkg::OBKT_W'(bkt_r);
            o_items_r    <= chtg_pkg::OITEM_W'(ent_r);
            o_rsz_r      <= dbl_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == chtg_pkg::CFG_INIT_BUCKETS) begin
          fv_r  <= '0;
          bkt_r <= clamp_bkt(cfg_data);
          ent_r <= '0;
          dbl_r <= '0;
        end else if (cfg_index == chtg_pkg::CFG_LOAD_THR) begin
          thr_r <= cfg_data[chtg_pkg::THR_W-1:0];
        end
      end
    end
  end

  `CHTG_ASSERT_IMPL(a_idle_mod_free, state_r == S_IDLE, !mod_busy_r, "modulo busy while idle")
  `CHTG_ASSERT_IMPL(a_bkt_range, 1'b1, (bkt_r != '0) && (32'(bkt_r) <= MAX_BUCKETS),
                    "bucket count out of range")
  `CHTG_ASSERT_IMPL(a_fill_range, fill_we, 32'(fill_wdata) <= SLOTS_PER_BUCKET,
                    "bucket fill overflow")
  `CHTG_ASSERT_NEXT(a_accept_busy, in_acc, state_r == S_HASH, "request not started")

endmodule

FILE: sv/chtg_ram.sv
// ---------------------------------------------------------------------------
// chtg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module chtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
